FILE: src/ffdp_pkg.sv
// ffdp_pkg: shared constants and types for the fixed-frame decimal parser.
// Used by the front, queue, back and top-level modules. No dependencies.
`default_nettype none

package ffdp_pkg;

    // Frame geometry and character constants
    localparam int PAYLOAD_DIGITS = 5;
    localparam int DIGIT_CNT_W    = $clog2(PAYLOAD_DIGITS + 1);
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE   = 2'd1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes handed from front to back
    typedef enum logic [1:0] {
        OP_TYPE  = 2'd0,   // latch command type, clear accumulator
        OP_DIGIT = 2'd1,   // accumulate one payload digit
        OP_EMIT  = 2'd2    // end byte matched: deliver result
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

FILE: src/ffdp_front.sv
// ffdp_front: configuration registers and frame phase tracking.
// Classifies each accepted byte into an operation for the back end. Uses ffdp_pkg.
`default_nettype none

module ffdp_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ffdp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                         cfg_data,
    input  wire logic                               accept,
    input  wire logic [7:0]                         rx_byte,
    output logic                                    push,
    output ffdp_pkg::op_t                           push_op
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_DIGITS,
        PH_END
    } phase_t;

    phase_t                             phase_reg;
    phase_t                             phase_next;
    logic [ffdp_pkg::DIGIT_CNT_W-1:0]   count_reg;
    logic [ffdp_pkg::DIGIT_CNT_W-1:0]   count_next;
    logic [7:0]                         start_byte_reg;
    logic [7:0]                         end_byte_reg;

    // Configuration writes; other indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'h00;
            end_byte_reg   <= 8'h00;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ffdp_pkg::CFG_START_BYTE)
                start_byte_reg <= cfg_data;
            else if (cfg_index == ffdp_pkg::CFG_END_BYTE)
                end_byte_reg <= cfg_data;
        end
    end

    // Byte classification and next phase
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        push         = 1'b0;
        push_op.kind = ffdp_pkg::OP_DIGIT;
        push_op.data = rx_byte;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        count_next = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    push         = 1'b1;
                    push_op.kind = ffdp_pkg::OP_TYPE;
                    phase_next   = PH_DIGITS;
                end
                PH_DIGITS:
                begin
                    push         = 1'b1;
                    push_op.kind = ffdp_pkg::OP_DIGIT;
                    count_next   = count_reg + 1'b1;
                    if (count_reg ==
                        ffdp_pkg::DIGIT_CNT_W'(ffdp_pkg::PAYLOAD_DIGITS - 1))
                        phase_next = PH_END;
                end
                PH_END:
                begin
                    // mismatch: byte dropped, back to hunting
                    push         = (rx_byte == end_byte_reg);
                    push_op.kind = ffdp_pkg::OP_EMIT;
                    phase_next   = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ffdp_queue.sv
// ffdp_queue: short operation queue between front and back ends.
// Register-based FIFO of ffdp_pkg::op_t entries. Uses ffdp_pkg.
`default_nettype none

module ffdp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ffdp_pkg::op_t  push_op,
    input  wire logic           pop,
    output ffdp_pkg::op_t       head_op,
    output ffdp_pkg::q_status_t status
);

    ffdp_pkg::op_t                  entry_reg [ffdp_pkg::QUEUE_DEPTH];
    logic [ffdp_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ffdp_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ffdp_pkg::QCNT_W-1:0]    count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == ffdp_pkg::QCNT_W'(ffdp_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_op      = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == ffdp_pkg::QPTR_W'(ffdp_pkg::QUEUE_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == ffdp_pkg::QPTR_W'(ffdp_pkg::QUEUE_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: src/ffdp_back.sv
// ffdp_back: executes queued operations: type latch, decimal accumulate, emit.
// Holds the result output register. Uses ffdp_pkg.
`default_nettype none

module ffdp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ffdp_pkg::op_t  head_op,
    input  wire logic           head_valid,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          frame_type,
    output logic [31:0]         frame_value,
    output logic                value_is_zero
);

    logic [7:0]     type_reg;
    logic [31:0]    acc_reg;
    logic [31:0]    acc_next;
    logic           out_valid_reg;
    logic           out_free;
    logic [31:0]    acc_times10;
    logic [7:0]     frame_type_reg;
    logic [31:0]    frame_value_reg;
    logic           value_is_zero_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // Only an emit has to wait for the output register
    assign pop = head_valid && ((head_op.kind != ffdp_pkg::OP_EMIT) || out_free);

    // acc * 10 as two shifts, wraps modulo 2^32
    assign acc_times10 = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};

    always_comb
    begin
        acc_next = acc_reg;
        if (pop)
        begin
            unique case (head_op.kind)
                ffdp_pkg::OP_TYPE:  acc_next = '0;
                ffdp_pkg::OP_DIGIT: acc_next = acc_times10 + {24'h000000, head_op.data}
                                             - {24'h000000, ffdp_pkg::ASCII_ZERO};
                ffdp_pkg::OP_EMIT:  acc_next = acc_reg;
                default:            acc_next = acc_reg;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= 8'h00;
            acc_reg  <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (pop && (head_op.kind == ffdp_pkg::OP_TYPE))
                type_reg <= head_op.data;
        end
    end

    // Result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && (head_op.kind == ffdp_pkg::OP_EMIT))
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head_op.kind == ffdp_pkg::OP_EMIT))
        begin
            frame_type_reg    <= type_reg;
            frame_value_reg   <= acc_reg;
            value_is_zero_reg <= (acc_reg == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_type    = frame_type_reg;
    assign frame_value   = frame_value_reg;
    assign value_is_zero = value_is_zero_reg;

endmodule

`default_nettype wire

FILE: src/fixed_frame_ascii_decimal_parser_unit.sv
// fixed_frame_ascii_decimal_parser_unit: top level of the serial frame parser.
// Instantiates ffdp_front, ffdp_queue and ffdp_back; uses ffdp_pkg.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+----------------------------------------
//  config   | cfg_we                | cfg_index[1:0], cfg_data[7:0]
//  input    | in_valid / in_stall   | rx_byte[7:0]
//  result   | out_valid / out_stall | frame_type[7:0], frame_value[31:0],
//           |                       | value_is_zero
//
// One byte is accepted every cycle while the two-entry operation queue has room.
// out_valid rises after the end byte is accepted and passes the queue entry, then the
// output register; the emit waits in the queue while a held result is stalled.
// The back end retires one operation per cycle unless an emit waits on a held
// result, so in_stall rises only while out_stall holds.
// Reset clears phase, digit count, queue, accumulator and both config registers.
`default_nettype none

module fixed_frame_ascii_decimal_parser_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ffdp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         rx_byte,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [7:0]                              frame_type,
    output logic [31:0]                             frame_value,
    output logic                                    value_is_zero
);

    logic                   accept;
    logic                   push;
    ffdp_pkg::op_t          push_op;
    logic                   pop;
    ffdp_pkg::op_t          head_op;
    ffdp_pkg::q_status_t    q_status;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    ffdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_op   (push_op)
    );

    ffdp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    ffdp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_op       (head_op),
        .head_valid    (!q_status.empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_type    (frame_type),
        .frame_value   (frame_value),
        .value_is_zero (value_is_zero)
    );

    // Queue status is never both full and empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // Zero flag agrees with the delivered value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value_is_zero == (frame_value == 32'h0)))
        else $error("value_is_zero disagrees with frame_value");

    // Input stall only arises while a result is held back downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && $past(out_stall)))
        else $error("input stalled without output back-pressure");

    // A non-emit operation at the queue head never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && head_op.kind != ffdp_pkg::OP_EMIT) |-> pop)
        else $error("back end failed to retire a non-emit operation");

endmodule

`default_nettype wire
